### rtl/wcf_pkg.sv
`default_nettype none

package wcf_pkg;

    localparam int          DRAW_W      = 31;
    localparam int          COUNT_W     = 15;
    localparam logic [47:0] RNG_RESET   = 48'h1234ABCD330E;
    localparam logic [15:0] SEED_LOW    = 16'h330E;
    localparam logic [23:0] LCG_MUL_LO  = 24'hECE66D;
    localparam logic [23:0] LCG_MUL_HI  = 24'h0005DE;
    localparam logic [47:0] LCG_ADD     = 48'hB;
    localparam logic [7:0]  SIDE_RESET  = 8'd50;

    localparam logic [0:0]  CFG_SIDE    = 1'b0;
    localparam logic [0:0]  CFG_THRESH  = 1'b1;

    localparam logic [2:0]  DIR_UP      = 3'd0;
    localparam logic [2:0]  DIR_DOWN    = 3'd1;
    localparam logic [2:0]  DIR_LEFT    = 3'd2;
    localparam logic [2:0]  DIR_RIGHT   = 3'd3;
    localparam logic [2:0]  DIR_DONE    = 3'd4;

    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_READ    = 2'd1,
        MODE_CLUSTER = 2'd2,
        MODE_RESEED  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_RNG_ROW,
        ST_MOD_ROW,
        ST_RNG_COL,
        ST_MOD_COL,
        ST_START_RD,
        ST_NB_RD,
        ST_NB_CHK,
        ST_JOIN,
        ST_POP_LD,
        ST_FIN
    } fsm_t;

    typedef struct packed {
        logic step;
        logic load;
    } rng_ctl_t;

endpackage

`default_nettype wire

### rtl/wcf_ram.sv
`default_nettype none

module wcf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

### rtl/wcf_rng.sv
`default_nettype none

module wcf_rng (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wcf_pkg::rng_ctl_t  ctl,
    input  wire logic [31:0]        seed,
    output logic      [47:0]        state,
    output logic                    done
);

    import wcf_pkg::*;

    logic [47:0] state_reg;
    logic [47:0] acc_reg;
    logic [1:0]  phase_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [23:0] op_a;
    logic [23:0] op_b;
    logic [47:0] prod;
    logic [47:0] addend;
    logic [47:0] acc_sum;

    // state * mul mod 2^48 as three 24-bit partial products, one a cycle
    always_comb
    begin
        op_a    = (phase_reg == 2'd2) ? state_reg[47:24] : state_reg[23:0];
        op_b    = (phase_reg == 2'd1) ? LCG_MUL_HI : LCG_MUL_LO;
        prod    = 48'(op_a * op_b);
        addend  = (phase_reg == 2'd0) ? prod : {prod[23:0], 24'd0};
        acc_sum = ((phase_reg == 2'd0) ? 48'd0 : acc_reg) + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RNG_RESET;
            phase_reg <= 2'd0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.load)
            begin
                state_reg <= {seed, SEED_LOW};
            end
            else if (ctl.step)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                if (phase_reg == 2'd3)
                begin
                    state_reg <= acc_reg + LCG_ADD;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                else
                begin
                    phase_reg <= phase_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && phase_reg != 2'd3)
        begin
            acc_reg <= acc_sum;
        end
    end

    assign state = state_reg;
    assign done  = done_reg;

endmodule

`default_nettype wire

### rtl/wcf_mod.sv
`default_nettype none

module wcf_mod #(
    parameter int DW = 8,
    parameter int RW = 7
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [wcf_pkg::DRAW_W-1:0] dividend,
    input  wire logic [DW-1:0]              divisor,
    output logic      [RW-1:0]              rem,
    output logic                            done
);

    import wcf_pkg::*;

    localparam int CNT_W = $clog2(DRAW_W + 1);

    logic [DRAW_W-1:0] shift_reg;
    logic [DW-1:0]     div_reg;
    logic [DW-1:0]     rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DW:0]       trial;
    logic [DW-1:0]     rem_next;

    // restoring remainder, one dividend bit a cycle
    always_comb
    begin
        trial = {rem_reg, shift_reg[DRAW_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = DW'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = DW'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DRAW_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            div_reg   <= divisor;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[DRAW_W-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign rem  = RW'(rem_reg);
    assign done = done_reg;

endmodule

`default_nettype wire

### rtl/wolff_cluster_flip.sv
// spin write and reseed: idle, finish, output register; a spin read adds the
// read state; cluster step: start row and column, each a generator step and a
// remainder, then per neighbour a read and check, a drawn number if of equal
// spin, and pops; the rate is set by the single-port spin memory and generator
// a new request is taken once the previous one has reached the output register
// reset: async, clears control, generator to its seed value, side 50, threshold 0
`default_nettype none

module wolff_cluster_flip #(
    parameter int MAX_SIDE = 128
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [47:0]                   cfg_data,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire logic [1:0]                    mode,
    input  wire logic [6:0]                    row,
    input  wire logic [6:0]                    col,
    input  wire logic                          spin_value,
    input  wire logic [31:0]                   seed_value,
    output logic                               resp_valid,
    input  wire logic                          resp_ready,
    output logic                               spin_out,
    output logic      [wcf_pkg::COUNT_W-1:0]   cluster_size
);

    import wcf_pkg::*;

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int GAW   = 2 * CW;
    localparam int GDEPTH = 2 ** GAW;
    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int SAW   = $clog2(CELLS);
    localparam int EW    = 2 * CW + 3;

    fsm_t state_reg, state_next;

    logic [7:0]         side_reg;
    logic [47:0]        thresh_reg;
    logic [CW-1:0]      cur_row_reg, cur_row_next;
    logic [CW-1:0]      cur_col_reg, cur_col_next;
    logic [2:0]         cur_dir_reg, cur_dir_next;
    logic [CW-1:0]      nb_row_reg, nb_row_next;
    logic [CW-1:0]      nb_col_reg, nb_col_next;
    logic [SAW-1:0]     sp_reg, sp_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               clus_spin_reg, clus_spin_next;
    logic               res_spin_reg, res_spin_next;
    logic               in_store_reg, in_store_next;
    logic               resp_valid_reg, resp_valid_next;
    logic               spin_out_reg, spin_out_next;
    logic [COUNT_W-1:0] size_reg, size_next;

    logic [SW-1:0]      side_use;
    logic [CW-1:0]      side_last;
    logic [SW:0]        row_plus;
    logic [SW:0]        col_plus;
    logic [CW-1:0]      nb_row;
    logic [CW-1:0]      nb_col;
    logic               in_store;

    logic               grid_we;
    logic [GAW-1:0]     grid_addr;
    logic               grid_wdata;
    logic               grid_rdata;
    logic               stack_we;
    logic [SAW-1:0]     stack_addr;
    logic [EW-1:0]      stack_wdata;
    logic [EW-1:0]      stack_rdata;

    rng_ctl_t           rng_ctl;
    logic [47:0]        rng_state;
    logic               rng_done;
    logic               mod_start;
    logic [CW-1:0]      mod_rem;
    logic               mod_done;

    wcf_ram #(.WIDTH(1), .DEPTH(GDEPTH)) u_grid (
        .clk   (clk),
        .we    (grid_we),
        .addr  (grid_addr),
        .wdata (grid_wdata),
        .rdata (grid_rdata)
    );

    wcf_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_stack (
        .clk   (clk),
        .we    (stack_we),
        .addr  (stack_addr),
        .wdata (stack_wdata),
        .rdata (stack_rdata)
    );

    wcf_rng u_rng (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rng_ctl),
        .seed  (seed_value),
        .state (rng_state),
        .done  (rng_done)
    );

    wcf_mod #(.DW(SW), .RW(CW)) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (rng_state[47:17]),
        .divisor  (side_use),
        .rem      (mod_rem),
        .done     (mod_done)
    );

    // side clamped to the stored range
    always_comb
    begin
        if (side_reg < 8'd2)
        begin
            side_use = SW'(2);
        end
        else if (int'(side_reg) > MAX_SIDE)
        begin
            side_use = SW'(MAX_SIDE);
        end
        else
        begin
            side_use = SW'(side_reg);
        end
        side_last = CW'(side_use - SW'(1));
        in_store  = (int'(row) < MAX_SIDE) && (int'(col) < MAX_SIDE);
    end

    // periodic neighbour of the current site
    always_comb
    begin
        row_plus = (SW+1)'(cur_row_reg) + (SW+1)'(1);
        col_plus = (SW+1)'(cur_col_reg) + (SW+1)'(1);
        nb_row   = cur_row_reg;
        nb_col   = cur_col_reg;
        case (cur_dir_reg)
            DIR_UP:
            begin
                nb_row = (cur_row_reg == '0) ? side_last : cur_row_reg - CW'(1);
            end
            DIR_DOWN:
            begin
                nb_row = (row_plus >= (SW+1)'(side_use)) ? '0 : CW'(row_plus);
            end
            DIR_LEFT:
            begin
                nb_col = (cur_col_reg == '0) ? side_last : cur_col_reg - CW'(1);
            end
            DIR_RIGHT:
            begin
                nb_col = (col_plus >= (SW+1)'(side_use)) ? '0 : CW'(col_plus);
            end
            default:
            begin
                nb_row = cur_row_reg;
                nb_col = cur_col_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (mode_t'(mode))
                        MODE_READ:    state_next = ST_READ;
                        MODE_CLUSTER: state_next = ST_RNG_ROW;
                        default:      state_next = ST_FIN;
                    endcase
                end
            end
            ST_READ:     state_next = ST_FIN;
            ST_RNG_ROW:  if (rng_done) state_next = ST_MOD_ROW;
            ST_MOD_ROW:  if (mod_done) state_next = ST_RNG_COL;
            ST_RNG_COL:  if (rng_done) state_next = ST_MOD_COL;
            ST_MOD_COL:  if (mod_done) state_next = ST_START_RD;
            ST_START_RD: state_next = ST_NB_RD;
            ST_NB_RD:
            begin
                if (cur_dir_reg != DIR_DONE)
                begin
                    state_next = ST_NB_CHK;
                end
                else if (sp_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_POP_LD;
                end
            end
            ST_NB_CHK:
            begin
                state_next = (grid_rdata == clus_spin_reg) ? ST_JOIN : ST_NB_RD;
            end
            ST_JOIN:     if (rng_done) state_next = ST_NB_RD;
            ST_POP_LD:   state_next = ST_NB_RD;
            ST_FIN:      if (!resp_valid_reg || resp_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready       = (state_reg == ST_IDLE);
        grid_we         = 1'b0;
        grid_addr       = {nb_row, nb_col};
        grid_wdata      = ~clus_spin_reg;
        stack_we        = 1'b0;
        stack_addr      = sp_reg;
        stack_wdata     = {cur_row_reg, cur_col_reg, cur_dir_reg};
        rng_ctl         = '0;
        mod_start       = 1'b0;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        cur_dir_next    = cur_dir_reg;
        nb_row_next     = nb_row_reg;
        nb_col_next     = nb_col_reg;
        sp_next         = sp_reg;
        count_next      = count_reg;
        clus_spin_next  = clus_spin_reg;
        res_spin_next   = res_spin_reg;
        in_store_next   = in_store_reg;
        resp_valid_next = resp_valid_reg & ~resp_ready;
        spin_out_next   = spin_out_reg;
        size_next       = size_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    in_store_next = in_store;
                    res_spin_next = 1'b0;
                    count_next    = '0;
                    grid_addr     = {CW'(row), CW'(col)};
                    grid_wdata    = spin_value;
                    unique case (mode_t'(mode))
                        MODE_WRITE:   grid_we      = in_store;
                        MODE_READ:    grid_we      = 1'b0;
                        MODE_CLUSTER: rng_ctl.step = 1'b1;
                        MODE_RESEED:  rng_ctl.load = 1'b1;
                        default:      grid_we      = 1'b0;
                    endcase
                end
            end
            ST_READ:
            begin
                res_spin_next = in_store_reg & grid_rdata;
            end
            ST_RNG_ROW, ST_RNG_COL:
            begin
                mod_start = rng_done;
            end
            ST_MOD_ROW:
            begin
                if (mod_done)
                begin
                    cur_row_next = mod_rem;
                    rng_ctl.step = 1'b1;
                end
            end
            ST_MOD_COL:
            begin
                grid_addr = {cur_row_reg, mod_rem};
                if (mod_done)
                begin
                    cur_col_next = mod_rem;
                end
            end
            ST_START_RD:
            begin
                // flip the start site, keep its old spin as the cluster spin
                clus_spin_next = grid_rdata;
                grid_we        = 1'b1;
                grid_addr      = {cur_row_reg, cur_col_reg};
                grid_wdata     = ~grid_rdata;
                count_next     = COUNT_W'(1);
                cur_dir_next   = DIR_UP;
                sp_next        = '0;
            end
            ST_NB_RD:
            begin
                if (cur_dir_reg != DIR_DONE)
                begin
                    nb_row_next  = nb_row;
                    nb_col_next  = nb_col;
                    cur_dir_next = cur_dir_reg + 3'd1;
                end
                else if (sp_reg != '0)
                begin
                    stack_addr = sp_reg - SAW'(1);
                    sp_next    = sp_reg - SAW'(1);
                end
            end
            ST_NB_CHK:
            begin
                rng_ctl.step = (grid_rdata == clus_spin_reg);
            end
            ST_JOIN:
            begin
                grid_addr = {nb_row_reg, nb_col_reg};
                if (rng_done && rng_state <= thresh_reg)
                begin
                    // push the current site and descend into the neighbour
                    grid_we      = 1'b1;
                    stack_we     = 1'b1;
                    sp_next      = sp_reg + SAW'(1);
                    cur_row_next = nb_row_reg;
                    cur_col_next = nb_col_reg;
                    cur_dir_next = DIR_UP;
                    count_next   = count_reg + COUNT_W'(1);
                end
            end
            ST_POP_LD:
            begin
                {cur_row_next, cur_col_next, cur_dir_next} = stack_rdata;
            end
            ST_FIN:
            begin
                if (!resp_valid_reg || resp_ready)
                begin
                    resp_valid_next = 1'b1;
                    spin_out_next   = res_spin_reg;
                    size_next       = count_reg;
                end
            end
            default:
            begin
                grid_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            side_reg       <= SIDE_RESET;
            thresh_reg     <= '0;
            resp_valid_reg <= 1'b0;
            sp_reg         <= '0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            resp_valid_reg <= resp_valid_next;
            sp_reg         <= sp_next;
            count_reg      <= count_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SIDE:   side_reg   <= cfg_data[7:0];
                    CFG_THRESH: thresh_reg <= cfg_data;
                    default:    side_reg   <= side_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_row_reg   <= cur_row_next;
        cur_col_reg   <= cur_col_next;
        cur_dir_reg   <= cur_dir_next;
        nb_row_reg    <= nb_row_next;
        nb_col_reg    <= nb_col_next;
        clus_spin_reg <= clus_spin_next;
        res_spin_reg  <= res_spin_next;
        in_store_reg  <= in_store_next;
        spin_out_reg  <= spin_out_next;
        size_reg      <= size_next;
    end

    assign resp_valid   = resp_valid_reg;
    assign spin_out     = spin_out_reg;
    assign cluster_size = size_reg;

endmodule

`default_nettype wire

### rtl/wcf_checker.sv
`default_nettype none

module wcf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        resp_valid,
    input wire logic        resp_ready,
    input wire logic        spin_out,
    input wire logic [14:0] cluster_size
);

    // a result waiting at the output keeps its payload
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_ready |=> resp_valid && $stable(spin_out)
            && $stable(cluster_size))
        else $error("stalled result changed");

    // a result carries either a read spin or a cluster size, never both
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid |-> !(spin_out && cluster_size != 15'd0))
        else $error("spin and cluster size both set");

    // ready drops once a request is accepted; requests are never taken back to back
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted back to back");

endmodule

bind wolff_cluster_flip wcf_checker u_wcf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .resp_valid   (resp_valid),
    .resp_ready   (resp_ready),
    .spin_out     (spin_out),
    .cluster_size (cluster_size)
);

`default_nettype wire
